FILE: rtl/i2ctrb_pkg.sv
package i2ctrb_pkg;

  localparam int BANK_SIZE = 64;
  localparam int IDX_W     = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [255:0][IDX_W-1:0] wrap_tbl_t;

  typedef enum logic [1:0] {
    CMD_BUS   = 2'd0,
    CMD_HWR   = 2'd1,
    CMD_HRD   = 2'd2,
    CMD_TAKE  = 2'd3
  } cmd_t;

  localparam logic [1:0] PH_CODE_IDLE = 2'd0;
  localparam logic [1:0] PH_CODE_PTR  = 2'd1;
  localparam logic [1:0] PH_CODE_RX   = 2'd2;
  localparam logic [1:0] PH_CODE_TX   = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_PTR  = 4'b0010,
    PH_RX   = 4'b0100,
    PH_TX   = 4'b1000
  } ph_t;

  function automatic wrap_tbl_t build_wrap();
    wrap_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = idx_t'(i % BANK_SIZE);
    end
    return t;
  endfunction

  localparam wrap_tbl_t WRAP_TBL = build_wrap();

  function automatic logic [1:0] ph_code(ph_t p);
    logic [1:0] c;
    case (p)
      PH_IDLE: c = PH_CODE_IDLE;
      PH_PTR:  c = PH_CODE_PTR;
      PH_RX:   c = PH_CODE_RX;
      PH_TX:   c = PH_CODE_TX;
      default: c = PH_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/i2c_target_register_bank.sv
// Items pass the input register, then the result register, with the bank read
// port registered alongside. Bus and host share both bank ports.
// Throughput: one item per cycle while out_stall is low.
// Reset (rst_n low, synchronous): phase idle, pointer 0, write flag clear,
// all per-entry valid bits clear so the bank reads as zeros. No clearing pass.
module i2c_target_register_bank (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic       in_addr_match,
  input  logic       in_dir_read,
  input  logic       in_rx_valid,
  input  logic [7:0] in_rx_byte,
  input  logic       in_tx_request,
  input  logic       in_stop_seen,
  input  logic [7:0] in_host_index,
  input  logic [7:0] in_host_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tx_load,
  output logic [7:0] out_tx_byte,
  output logic [7:0] out_host_data,
  output logic       out_write_seen,
  output logic [1:0] out_bus_phase
);
  import i2ctrb_pkg::*;

  // input register
  logic       s1_v_r;
  logic [1:0] s1_cmd_r;
  logic       s1_am_r, s1_dir_r, s1_rxv_r, s1_txr_r, s1_stop_r;
  logic [7:0] s1_rx_r, s1_hidx_r, s1_hval_r;

  // architectural state
  ph_t  phase_r, phase_nxt;
  idx_t pointer_r, pointer_nxt;
  logic wrote_r, wrote_nxt;
  logic [BANK_SIZE-1:0] vld_r;
  logic [7:0] mem [BANK_SIZE];

  // result register
  logic       out_valid_r;
  logic       o_tx_load_r, o_fwd_r, o_host_rd_r, o_ws_r;
  logic [7:0] o_fwd_byte_r;
  logic [1:0] o_phase_r;
  logic [7:0] rd_data_r;
  logic       rd_vld_r;

  logic       adv2, in_acc;
  logic       we;
  idx_t       wa, ra;
  logic [7:0] wd;
  logic       tx_load, fwd, host_rd, ws;

  assign adv2     = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !adv2;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (adv2) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_cmd;
      s1_am_r   <= in_addr_match;
      s1_dir_r  <= in_dir_read;
      s1_rxv_r  <= in_rx_valid;
      s1_rx_r   <= in_rx_byte;
      s1_txr_r  <= in_tx_request;
      s1_stop_r <= in_stop_seen;
      s1_hidx_r <= in_host_index;
      s1_hval_r <= in_host_value;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    pointer_nxt = pointer_r;
    wrote_nxt   = wrote_r;
    we          = 1'b0;
    wa          = pointer_r;
    wd          = s1_rx_r;
    ra          = pointer_r;
    tx_load     = 1'b0;
    fwd         = 1'b0;
    host_rd     = 1'b0;
    ws          = 1'b0;
    case (s1_cmd_r)
      CMD_BUS: begin
        if (s1_am_r) begin
          if (s1_dir_r) begin
            phase_nxt = PH_TX;
            tx_load   = 1'b1;
          end else begin
            phase_nxt = PH_PTR;
          end
        end
        if (s1_rxv_r) begin
          if (phase_nxt == PH_PTR) begin
            pointer_nxt = WRAP_TBL[s1_rx_r];
            phase_nxt   = PH_RX;
          end else begin
            we        = 1'b1;
            wrote_nxt = 1'b1;
          end
        end
        if (s1_txr_r) begin
          tx_load = 1'b1;
          ra      = pointer_nxt;
          fwd     = we;
        end
        if (s1_stop_r) begin
          phase_nxt = PH_IDLE;
        end
      end
      CMD_HWR: begin
        we = 1'b1;
        wa = WRAP_TBL[s1_hidx_r];
        wd = s1_hval_r;
      end
      CMD_HRD: begin
        host_rd = 1'b1;
        ra      = WRAP_TBL[s1_hidx_r];
      end
      default: begin
        ws        = wrote_r;
        wrote_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pointer_r   <= '0;
      wrote_r     <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv2) begin
        phase_r   <= phase_nxt;
        pointer_r <= pointer_nxt;
        wrote_r   <= wrote_nxt;
        if (we) begin
          vld_r[wa] <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      if (we) begin
        mem[wa] <= wd;
      end
      rd_data_r    <= mem[ra];
      rd_vld_r     <= vld_r[ra];
      o_tx_load_r  <= tx_load;
      o_fwd_r      <= fwd;
      o_fwd_byte_r <= wd;
      o_host_rd_r  <= host_rd;
      o_ws_r       <= ws;
      o_phase_r    <= ph_code(phase_nxt);
    end
  end

  logic [7:0] mem_byte;
  assign mem_byte       = rd_vld_r ? rd_data_r : 8'h00;
  assign out_valid      = out_valid_r;
  assign out_tx_load    = o_tx_load_r;
  assign out_tx_byte    = o_tx_load_r ? (o_fwd_r ? o_fwd_byte_r : mem_byte) : 8'h00;
  assign out_host_data  = o_host_rd_r ? mem_byte : 8'h00;
  assign out_write_seen = o_ws_r;
  assign out_bus_phase  = o_phase_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (adv2 && we) |=> vld_r[$past(wa)])
    else $error("bank write did not mark entry valid");

  a_fwd_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_fwd_r) |-> o_tx_load_r)
    else $error("forwarded byte without transmit load");

  a_ptr_byte_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (adv2 && s1_cmd_r == CMD_BUS && s1_rxv_r && !s1_stop_r && phase_nxt != PH_TX
     && !we) |=> (phase_r == PH_RX))
    else $error("pointer byte did not enter data receive");

  a_host_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_host_rd_r) |-> (!o_tx_load_r && !o_ws_r))
    else $error("host read result mixed with bus or flag result");

endmodule
